// ===== design/ulpe_pkg.sv =====
// Package: shared types, constants and helper functions for the uri-list path extractor.
`timescale 1ns / 1ps

package ulpe_pkg;

    // Line parse modes
    typedef enum logic [2:0] {
        MODE_START   = 3'd0,
        MODE_PREFIX  = 3'd1,
        MODE_HOST    = 3'd2,
        MODE_BODY    = 3'd3,
        MODE_COMMENT = 3'd4
    } t_mode;

    // One result item
    typedef struct packed {
        logic [7:0] path_byte;
        logic       byte_valid;
        logic       path_end;
    } t_item;

    localparam int unsigned PREFIX_LEN = 7;
    localparam int unsigned MAX_ITEMS  = 8;

    localparam logic [7:0] CHAR_CR      = 8'd13;
    localparam logic [7:0] CHAR_LF      = 8'd10;
    localparam logic [7:0] CHAR_HASH    = 8'h23;
    localparam logic [7:0] CHAR_PERCENT = 8'h25;
    localparam logic [7:0] CHAR_SLASH   = 8'h2f;

    // Characters of "file://"
    function automatic logic [7:0] prefix_char(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h66; // f
            3'd1:    c = 8'h69; // i
            3'd2:    c = 8'h6c; // l
            3'd3:    c = 8'h65; // e
            3'd4:    c = 8'h3a; // :
            3'd5:    c = 8'h2f; // /
            3'd6:    c = 8'h2f; // /
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // Hex digit value; bit 4 set means not a hex digit
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        if (c >= 8'h30 && c <= 8'h39) begin
            v = {1'b0, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            v = {1'b0, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            v = {1'b0, 4'(c - 8'h37)};
        end else begin
            v = 5'h10;
        end
        return v;
    endfunction

    // Escape decode: both hex -> full byte, only first -> its value, else 0
    function automatic logic [7:0] decode_pair(input logic [7:0] a, input logic [7:0] b);
        logic [4:0] hi;
        logic [4:0] lo;
        logic [7:0] r;
        hi = hex_value(a);
        lo = hex_value(b);
        if (hi[4]) begin
            r = 8'h00;
        end else if (lo[4]) begin
            r = {4'h0, hi[3:0]};
        end else begin
            r = {hi[3:0], lo[3:0]};
        end
        return r;
    endfunction

endpackage

// ===== design/uri_list_path_extractor_top.sv =====
// Top level: streaming text/uri-list parser that emits percent-decoded file path bytes.
`timescale 1ns / 1ps

//  channel  | dir | tdata            | tuser        | tlast
//  s_axis   | in  | [7:0] text_byte  | -            | end_of_text
//  m_axis   | out | [7:0] path_byte  | [0] byte_valid | path_end
//
//  Each accepted byte is parsed combinationally; its result items (0 to 7) are
//  loaded into a small result queue and leave one per cycle from its head while
//  m_axis_tready is high. A new byte is taken when the queue is empty or its last
//  item leaves in that cycle, so ordinary path bytes stream at one item per cycle;
//  prefix flushes and cut escapes hold the input until their last item leaves.
//  Reset (i_rst_n low, synchronous) returns to line start and empties the queue.
module uri_list_path_extractor_top
    import ulpe_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input bytes
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] text_byte
    input  logic       s_axis_tlast,   // end_of_text
    // path items
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] path_byte
    output logic       m_axis_tuser,   // [0] byte_valid
    output logic       m_axis_tlast    // path_end
);

    localparam int unsigned CNT_W = $clog2(MAX_ITEMS + 1);

    // parse state
    t_mode       r_mode,  n_mode;
    logic [2:0]  r_pm,    n_pm;
    logic [1:0]  r_pct,   n_pct;
    logic [7:0]  r_fe,    n_fe;

    // result queue
    t_item            r_q [MAX_ITEMS];
    logic [CNT_W-1:0] r_cnt;

    // per-byte generation
    t_item            n_items [MAX_ITEMS];
    logic [CNT_W-1:0] n_num;
    t_item            tail [3];
    logic [1:0]       tail_n;
    logic [2:0]       flush_n;

    logic [7:0] b;
    logic       eol;
    logic       accept;
    logic       take;
    logic       match;

    assign b      = s_axis_tdata;
    assign eol    = s_axis_tlast || (b == CHAR_CR) || (b == CHAR_LF);
    assign take   = m_axis_tvalid && m_axis_tready;
    assign accept = s_axis_tvalid && s_axis_tready;
    assign match  = (r_pm < 3'(PREFIX_LEN)) && (b == prefix_char(r_pm));

    assign s_axis_tready = (r_cnt == '0) || ((r_cnt == CNT_W'(1)) && m_axis_tready);
    assign m_axis_tvalid = (r_cnt != '0);
    assign m_axis_tdata  = r_q[0].path_byte;
    assign m_axis_tuser  = r_q[0].byte_valid;
    assign m_axis_tlast  = r_q[0].path_end;

    // next state and tail items for the current byte
    always_comb begin
        logic do_body;
        do_body = 1'b0;
        n_mode  = r_mode;
        n_pm    = r_pm;
        n_pct   = r_pct;
        n_fe    = r_fe;
        flush_n = 3'd0;
        tail_n  = 2'd0;
        for (int k = 0; k < 3; k++) begin
            tail[k] = '{path_byte: 8'h00, byte_valid: 1'b0, path_end: 1'b0};
        end

        if (eol) begin
            unique case (r_mode)
                MODE_START, MODE_COMMENT: begin
                end
                MODE_PREFIX: begin
                    flush_n = r_pm;
                    tail[0] = '{path_byte: 8'h00, byte_valid: 1'b0, path_end: 1'b1};
                    tail_n  = 2'd1;
                end
                MODE_HOST: begin
                    tail[0] = '{path_byte: 8'h00, byte_valid: 1'b0, path_end: 1'b1};
                    tail_n  = 2'd1;
                end
                default: begin
                    // cut escape: pending bytes go out literally
                    if (r_pct == 2'd0) begin
                        tail[0] = '{path_byte: 8'h00, byte_valid: 1'b0, path_end: 1'b1};
                        tail_n  = 2'd1;
                    end else if (r_pct == 2'd1) begin
                        tail[0] = '{path_byte: CHAR_PERCENT, byte_valid: 1'b1, path_end: 1'b0};
                        tail[1] = '{path_byte: 8'h00, byte_valid: 1'b0, path_end: 1'b1};
                        tail_n  = 2'd2;
                    end else begin
                        tail[0] = '{path_byte: CHAR_PERCENT, byte_valid: 1'b1, path_end: 1'b0};
                        tail[1] = '{path_byte: r_fe, byte_valid: 1'b1, path_end: 1'b0};
                        tail[2] = '{path_byte: 8'h00, byte_valid: 1'b0, path_end: 1'b1};
                        tail_n  = 2'd3;
                    end
                end
            endcase
            n_mode = MODE_START;
            n_pm   = 3'd0;
            n_pct  = 2'd0;
            n_fe   = 8'h00;
        end else begin
            unique case (r_mode)
                MODE_START: begin
                    if (b == CHAR_HASH) begin
                        n_mode = MODE_COMMENT;
                    end else if (b == prefix_char(3'd0)) begin
                        n_mode = MODE_PREFIX;
                        n_pm   = 3'd1;
                    end else begin
                        do_body = 1'b1;
                    end
                end
                MODE_PREFIX: begin
                    if (match) begin
                        if (r_pm + 3'd1 >= 3'(PREFIX_LEN)) begin
                            n_pm   = 3'd0;
                            n_mode = MODE_HOST;
                        end else begin
                            n_pm = r_pm + 3'd1;
                        end
                    end else begin
                        flush_n = r_pm;
                        n_pm    = 3'd0;
                        do_body = 1'b1;
                    end
                end
                MODE_HOST: begin
                    do_body = (b == CHAR_SLASH);
                end
                MODE_COMMENT: begin
                end
                default: begin
                    do_body = 1'b1;
                end
            endcase

            // path body byte with escape handling
            if (do_body) begin
                n_mode = MODE_BODY;
                if (r_pct == 2'd0) begin
                    if (b == CHAR_PERCENT) begin
                        n_pct = 2'd1;
                    end else begin
                        tail[0] = '{path_byte: b, byte_valid: 1'b1, path_end: 1'b0};
                        tail_n  = 2'd1;
                    end
                end else if (r_pct == 2'd1) begin
                    n_fe  = b;
                    n_pct = 2'd2;
                end else begin
                    tail[0] = '{path_byte: decode_pair(r_fe, b), byte_valid: 1'b1,
                                path_end: 1'b0};
                    tail_n  = 2'd1;
                    n_pct   = 2'd0;
                    n_fe    = 8'h00;
                end
            end
        end
    end

    // assemble flushed prefix bytes followed by tail items
    always_comb begin
        logic [2:0] ti;
        n_num = CNT_W'(flush_n) + CNT_W'(tail_n);
        for (int k = 0; k < MAX_ITEMS; k++) begin
            ti = 3'(k) - flush_n;
            if (3'(k) < flush_n && k < PREFIX_LEN) begin
                n_items[k] = '{path_byte: prefix_char(3'(k)), byte_valid: 1'b1,
                               path_end: 1'b0};
            end else begin
                n_items[k] = tail[ti[1:0] == 2'd3 ? 2'd0 : ti[1:0]];
            end
        end
    end

    // parse state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_START;
            r_pm   <= 3'd0;
            r_pct  <= 2'd0;
            r_fe   <= 8'h00;
        end else if (accept) begin
            r_mode <= n_mode;
            r_pm   <= n_pm;
            r_pct  <= n_pct;
            r_fe   <= n_fe;
        end
    end

    // result queue count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (accept) begin
            r_cnt <= n_num;
        end else if (take) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    // result queue payload: load on accept (queue empty or last item leaving), shift toward the head on take
    always_ff @(posedge i_clk) begin
        if (accept) begin
            for (int k = 0; k < MAX_ITEMS; k++) begin
                r_q[k] <= n_items[k];
            end
        end else if (take) begin
            for (int k = 0; k < MAX_ITEMS - 1; k++) begin
                r_q[k] <= r_q[k+1];
            end
        end
    end

endmodule
